@@ hw/rtl/bmr_pkg.sv @@
`default_nettype none

package bmr_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_BYTES_DEF = 62;

    localparam int SLOT_W_MAX = 8;
    localparam int LEN_W_MAX  = 7;

    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

    localparam logic [5:0] CAP_UNLIMITED = 6'd63;

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_TOO_BIG = 3'd3,
        ST_TRUNC   = 3'd4
    } status_t;

    // A single result, or a stored message to be streamed out of a slot.
    typedef struct packed {
        logic                  is_stream;
        status_t               status;
        logic [SLOT_W_MAX-1:0] slot;
        logic [LEN_W_MAX-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bmr_ram.sv @@
`default_nettype none

module bmr_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bmr_cmd_q.sv @@
`default_nettype none

module bmr_cmd_q (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bmr_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output bmr_pkg::cmd_t      head,
    output logic               full,
    output logic               empty
);

    localparam int AW = bmr_pkg::CMD_Q_AW;
    localparam int CW = $clog2(bmr_pkg::CMD_Q_DEPTH + 1);

    bmr_pkg::cmd_t entry_reg [bmr_pkg::CMD_Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(bmr_pkg::CMD_Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bmr_front.sv @@
`default_nettype none

module bmr_front #(
    parameter int SLOT_COUNT = bmr_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = bmr_pkg::SLOT_BYTES_DEF,
    localparam int SLOT_W = $clog2(SLOT_COUNT),
    localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [15:0]             s_axis_tdata,
    input  wire logic                    s_axis_tlast,
    input  wire logic                    s_axis_tuser,
    output logic                         cmd_push,
    output bmr_pkg::cmd_t                cmd,
    input  wire logic                    cmd_full,
    input  wire logic                    stream_done,
    output logic                         byte_we,
    output logic [SLOT_W+OFF_W-1:0]      byte_waddr,
    output logic [7:0]                   byte_wdata
);

    localparam int FILL_W = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int PEND_W = $clog2(bmr_pkg::CMD_Q_DEPTH + 2);

    typedef enum logic [1:0] {
        S_ACCEPT = 2'b01,
        S_LEN_RD = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              drop_reg, drop_next;
    logic              ovf_reg, ovf_next;
    logic [5:0]        cap_reg, cap_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic              accept;
    logic              starting;
    logic              drop_v;
    logic              ovf_v;
    logic [FILL_W-1:0] fill_v;
    logic              pend_inc;
    logic              too_big;
    logic              len_we;
    logic [FILL_W-1:0] len_rdata;
    logic [SLOT_W-1:0] write_slot_adv;
    logic [SLOT_W-1:0] read_slot_adv;

    assign s_axis_tready = (state_reg == S_ACCEPT) && !cmd_full && (pend_reg == '0);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign byte_wdata    = s_axis_tdata[7:0];
    assign byte_waddr    = {write_slot_reg, fill_reg[OFF_W-1:0]};

    assign write_slot_adv = (write_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                        : write_slot_reg + 1'b1;
    assign read_slot_adv  = (read_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                       : read_slot_reg + 1'b1;

    assign starting = (fill_reg == '0) && !drop_reg && !ovf_reg;
    assign too_big  = (cap_reg != bmr_pkg::CAP_UNLIMITED)
                      && (7'(len_rdata) > {1'b0, cap_reg});

    bmr_ram #(
        .W(FILL_W),
        .D(SLOT_COUNT)
    ) u_len_ram (
        .clk  (clk),
        .we   (len_we),
        .waddr(write_slot_reg),
        .wdata(fill_v),
        .re   (1'b1),
        .raddr(read_slot_reg),
        .rdata(len_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        ovf_next        = ovf_reg;
        cap_next        = cap_reg;
        cmd_push        = 1'b0;
        cmd             = '0;
        byte_we         = 1'b0;
        len_we          = 1'b0;
        pend_inc        = 1'b0;
        drop_v          = drop_reg || (starting && (count_reg == CNT_W'(SLOT_COUNT)));
        ovf_v           = ovf_reg;
        fill_v          = fill_reg;

        if (!drop_v)
        begin
            if (fill_reg < FILL_W'(SLOT_BYTES))
            begin
                fill_v = fill_reg + 1'b1;
            end
            else
            begin
                ovf_v = 1'b1;
            end
        end

        case (state_reg)
            S_ACCEPT:
            begin
                if (accept && (s_axis_tuser == bmr_pkg::REQ_PUT))
                begin
                    byte_we = !drop_v && (fill_reg < FILL_W'(SLOT_BYTES));
                    if (s_axis_tlast)
                    begin
                        cmd_push = 1'b1;
                        if (drop_v)
                        begin
                            cmd.status = bmr_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.status      = ovf_v ? bmr_pkg::ST_TRUNC : bmr_pkg::ST_OK;
                            cmd.len         = 7'(fill_v);
                            len_we          = 1'b1;
                            write_slot_next = write_slot_adv;
                            count_next      = count_reg + 1'b1;
                        end
                        fill_next = '0;
                        drop_next = 1'b0;
                        ovf_next  = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_v;
                        drop_next = drop_v;
                        ovf_next  = ovf_v;
                    end
                end
                else if (accept)
                begin
                    if (count_reg == '0)
                    begin
                        cmd_push   = 1'b1;
                        cmd.status = bmr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cap_next   = s_axis_tdata[13:8];
                        state_next = S_LEN_RD;
                    end
                end
            end
            S_LEN_RD:
            begin
                cmd_push   = 1'b1;
                state_next = S_ACCEPT;
                if (too_big)
                begin
                    cmd.status = bmr_pkg::ST_TOO_BIG;
                end
                else
                begin
                    read_slot_next = read_slot_adv;
                    count_next     = count_reg - 1'b1;
                    cmd.status     = bmr_pkg::ST_OK;
                    if (len_rdata != '0)
                    begin
                        cmd.is_stream = 1'b1;
                        cmd.slot      = bmr_pkg::SLOT_W_MAX'(read_slot_reg);
                        cmd.len       = 7'(len_rdata);
                        pend_inc      = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase

        pend_next = pend_reg + PEND_W'(pend_inc) - PEND_W'(stream_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ACCEPT;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            drop_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            drop_reg       <= drop_next;
            ovf_reg        <= ovf_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOT_COUNT))
        else $error("stored message count exceeds the slot count");

    a_len_rd_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN_RD) |-> !cmd_full)
        else $error("command queue full while a get is being resolved");

    a_no_put_during_stream: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (pend_reg == '0))
        else $error("transaction accepted while a slot is still being read out");

endmodule

`default_nettype wire

@@ hw/rtl/bmr_back.sv @@
`default_nettype none

module bmr_back #(
    parameter int SLOT_COUNT = bmr_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = bmr_pkg::SLOT_BYTES_DEF,
    localparam int SLOT_W = $clog2(SLOT_COUNT),
    localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bmr_pkg::cmd_t           cmd,
    input  wire logic                    cmd_empty,
    output logic                         cmd_pop,
    output logic                         stream_done,
    output logic                         byte_re,
    output logic [SLOT_W+OFF_W-1:0]      byte_raddr,
    input  wire logic [7:0]              byte_rdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [23:0]                  m_axis_tdata,
    output logic                         m_axis_tlast
);

    localparam int FILL_W = $clog2(SLOT_BYTES + 1);

    logic              active_reg, active_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic [OFF_W-1:0]  idx_reg, idx_next;
    logic              ovalid_reg, ovalid_next;
    bmr_pkg::status_t  status_reg, status_next;
    logic [5:0]        mlen_reg, mlen_next;
    logic              last_reg, last_next;
    logic              sel_reg, sel_next;

    logic              adv;
    logic              idx_last;

    assign adv      = !ovalid_reg || m_axis_tready;
    assign idx_last = ((FILL_W'(idx_reg) + 1'b1) == len_reg);

    assign byte_raddr = active_reg ? {slot_reg, idx_reg}
                                   : {cmd.slot[SLOT_W-1:0], OFF_W'(0)};

    always_comb
    begin
        active_next = active_reg;
        slot_next   = slot_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        mlen_next   = mlen_reg;
        last_next   = last_reg;
        sel_next    = sel_reg;
        cmd_pop     = 1'b0;
        byte_re     = 1'b0;
        stream_done = 1'b0;

        if (adv)
        begin
            if (active_reg)
            begin
                byte_re     = 1'b1;
                ovalid_next = 1'b1;
                status_next = bmr_pkg::ST_OK;
                mlen_next   = 6'(len_reg);
                sel_next    = 1'b1;
                last_next   = idx_last;
                idx_next    = idx_reg + 1'b1;
                if (idx_last)
                begin
                    active_next = 1'b0;
                    stream_done = 1'b1;
                end
            end
            else if (!cmd_empty)
            begin
                cmd_pop     = 1'b1;
                ovalid_next = 1'b1;
                status_next = cmd.status;
                mlen_next   = 6'(cmd.len);
                if (cmd.is_stream)
                begin
                    byte_re   = 1'b1;
                    sel_next  = 1'b1;
                    slot_next = cmd.slot[SLOT_W-1:0];
                    len_next  = FILL_W'(cmd.len);
                    last_next = (cmd.len == 7'd1);
                    if (cmd.len == 7'd1)
                    begin
                        stream_done = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        idx_next    = OFF_W'(1);
                    end
                end
                else
                begin
                    sel_next  = 1'b0;
                    last_next = 1'b1;
                end
            end
            else
            begin
                ovalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        mlen_reg   <= mlen_next;
        last_reg   <= last_next;
        sel_reg    <= sel_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {7'b0, mlen_reg, (sel_reg ? byte_rdata : 8'h00), status_reg};

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (FILL_W'(idx_reg) < len_reg))
        else $error("read index ran past the message length");

endmodule

`default_nettype wire

@@ hw/rtl/bounded_message_ring_core.sv @@
// Put transactions are taken one per cycle while the command queue has room and no get is in
// progress; an end-of-message put queues its status result, which enters the result stage when
// that stage is free. A get that finds the ring empty is answered like an end-of-message put.
// Any other get holds the input while the slot length is read from the length RAM; a get that
// is served then sends its bytes at one per cycle, while the output is not stalled, through the
// byte RAM read port. The next transaction is accepted once the last byte of a get has been
// read from the RAM. Reset clears the ring pointers, counters and queues asynchronously; stored
// bytes and lengths are not cleared and there is no clearing pass.
`default_nettype none

module bounded_message_ring_core #(
    parameter int SLOT_COUNT = bmr_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = bmr_pkg::SLOT_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // in_byte[7:0], get_capacity[13:8], zero[15:14]
    input  wire logic        s_axis_tlast,   // end_of_message
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // status[2:0], out_byte[10:3], msg_length[16:11]
    output logic             m_axis_tlast    // last_of_run
);

    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int OFF_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int BYTE_DEPTH = SLOT_COUNT << OFF_W;

    logic                    cmd_push;
    bmr_pkg::cmd_t           push_cmd;
    bmr_pkg::cmd_t           head_cmd;
    logic                    cmd_full;
    logic                    cmd_empty;
    logic                    cmd_pop;
    logic                    stream_done;
    logic                    byte_we;
    logic [SLOT_W+OFF_W-1:0] byte_waddr;
    logic [7:0]              byte_wdata;
    logic                    byte_re;
    logic [SLOT_W+OFF_W-1:0] byte_raddr;
    logic [7:0]              byte_rdata;

    bmr_front #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd),
        .cmd_full     (cmd_full),
        .stream_done  (stream_done),
        .byte_we      (byte_we),
        .byte_waddr   (byte_waddr),
        .byte_wdata   (byte_wdata)
    );

    bmr_cmd_q u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .push_cmd(push_cmd),
        .pop     (cmd_pop),
        .head    (head_cmd),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    bmr_ram #(
        .W(8),
        .D(BYTE_DEPTH)
    ) u_byte_ram (
        .clk  (clk),
        .we   (byte_we),
        .waddr(byte_waddr),
        .wdata(byte_wdata),
        .re   (byte_re),
        .raddr(byte_raddr),
        .rdata(byte_rdata)
    );

    bmr_back #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .stream_done  (stream_done),
        .byte_re      (byte_re),
        .byte_raddr   (byte_raddr),
        .byte_rdata   (byte_rdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire
